// File: hdl/fac_pkg.sv
// Shared types and constants for the fall-alert controller.
`timescale 1ns / 1ps

package fac_pkg;

    // Mode codes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_IDLE    = 2'd1;
    localparam logic [1:0] MODE_FALLING = 2'd2;
    localparam logic [1:0] MODE_SHOW    = 2'd3;

    // Sensor setup commands
    localparam logic [1:0] SETUP_NONE   = 2'd0;
    localparam logic [1:0] SETUP_FALL   = 2'd1;
    localparam logic [1:0] SETUP_IMPACT = 2'd2;

    // Item kinds carried on tuser
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic REG_BLINK_PERIOD = 1'b0;
    localparam logic REG_SHOW_TIMEOUT = 1'b1;

    // Register reset values
    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd250;
    localparam logic [15:0] SHOW_TIMEOUT_RESET = 16'd10000;

    // Packed widths of the stream words
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // One input word
    typedef struct packed {
        logic        cmd;
        logic        fall_seen;
        logic        impact_seen;
        logic        key_pressed;
        logic [15:0] peak_accel;
    } fac_item_t;

    // One result word
    typedef struct packed {
        logic [1:0]  mode_now;
        logic        led_on;
        logic [1:0]  sensor_setup;
        logic        low_power_request;
        logic        clear_display;
        logic        display_valid;
        logic [15:0] display_value;
        logic        reset_peak;
    } fac_result_t;

endpackage

// File: hdl/fac_core.sv
// Mode machine, blink and timeout counters of the fall-alert controller.
`timescale 1ns / 1ps

module fac_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                item_fire,
    input  fac_pkg::fac_item_t  item,
    output fac_pkg::fac_result_t result
);
    import fac_pkg::*;

    logic [15:0] blink_period_reg;
    logic [15:0] show_timeout_reg;
    logic [1:0]  mode_reg,          mode_next;
    logic [15:0] blink_count_reg,   blink_count_next;
    logic [15:0] timeout_count_reg, timeout_count_next;
    logic        blink_done_reg,    blink_done_next;
    logic        timeout_done_reg,  timeout_done_next;
    logic        led_level_reg,     led_level_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg <= BLINK_PERIOD_RESET;
            show_timeout_reg <= SHOW_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLINK_PERIOD: blink_period_reg <= cfg_wdata;
                REG_SHOW_TIMEOUT: show_timeout_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Next state and result for the word on the input
    always_comb
    begin
        mode_next          = mode_reg;
        blink_count_next   = blink_count_reg;
        timeout_count_next = timeout_count_reg;
        blink_done_next    = blink_done_reg;
        timeout_done_next  = timeout_done_reg;
        led_level_next     = led_level_reg;
        result             = '0;

        if (item.cmd == CMD_TICK)
        begin
            // Both timers count down and flag done once they sit at zero.
            if (timeout_count_reg != 16'd0)
                timeout_count_next = timeout_count_reg - 16'd1;
            else
                timeout_done_next = 1'b1;
            if (blink_count_reg != 16'd0)
                blink_count_next = blink_count_reg - 16'd1;
            else
                blink_done_next = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_START:
                begin
                    led_level_next           = 1'b0;
                    result.clear_display     = 1'b1;
                    result.sensor_setup      = SETUP_FALL;
                    result.low_power_request = 1'b1;
                    mode_next                = MODE_IDLE;
                end
                MODE_IDLE:
                begin
                    if (item.fall_seen)
                    begin
                        led_level_next      = 1'b1;
                        result.sensor_setup = SETUP_IMPACT;
                        blink_count_next    = blink_period_reg;
                        blink_done_next     = 1'b0;
                        mode_next           = MODE_FALLING;
                    end
                end
                MODE_FALLING:
                begin
                    if (blink_done_reg)
                    begin
                        led_level_next   = !led_level_reg;
                        blink_count_next = blink_period_reg;
                        blink_done_next  = 1'b0;
                    end
                    if (item.impact_seen)
                    begin
                        result.display_valid = 1'b1;
                        result.display_value = item.peak_accel;
                        timeout_count_next   = show_timeout_reg;
                        timeout_done_next    = 1'b0;
                        mode_next            = MODE_SHOW;
                    end
                end
                MODE_SHOW:
                begin
                    result.display_valid = 1'b1;
                    result.display_value = item.peak_accel;
                    if (blink_done_reg)
                    begin
                        led_level_next   = !led_level_reg;
                        blink_count_next = blink_period_reg;
                        blink_done_next  = 1'b0;
                    end
                    if (timeout_done_reg || item.key_pressed)
                    begin
                        led_level_next           = 1'b0;
                        result.reset_peak        = 1'b1;
                        result.clear_display     = 1'b1;
                        result.sensor_setup      = SETUP_FALL;
                        result.low_power_request = 1'b1;
                        mode_next                = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end

        result.mode_now = mode_next;
        result.led_on   = led_level_next;
    end

    // State registers advance only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_START;
            blink_count_reg   <= 16'd0;
            timeout_count_reg <= 16'd0;
            blink_done_reg    <= 1'b0;
            timeout_done_reg  <= 1'b0;
            led_level_reg     <= 1'b0;
        end
        else if (item_fire)
        begin
            mode_reg          <= mode_next;
            blink_count_reg   <= blink_count_next;
            timeout_count_reg <= timeout_count_next;
            blink_done_reg    <= blink_done_next;
            timeout_done_reg  <= timeout_done_next;
            led_level_reg     <= led_level_next;
        end
    end

`ifndef SYNTHESIS
    // A tick never moves the mode machine.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.cmd == CMD_TICK |=> mode_reg == $past(mode_reg))
        else $error("tick changed the mode");

    // A tick word carries no command pulses.
    assert property (@(posedge clk) disable iff (!rst_n)
        item.cmd == CMD_TICK |-> result.sensor_setup == SETUP_NONE
            && !result.low_power_request && !result.clear_display
            && !result.display_valid && !result.reset_peak)
        else $error("tick result carries a command");

    // Leaving the start mode always lands in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && mode_reg == MODE_START && item.cmd == CMD_STEP
            |=> mode_reg == MODE_IDLE)
        else $error("start step did not reach idle");

    // The LED is dark in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> !led_level_reg)
        else $error("LED lit in idle");
`endif

endmodule

// File: hdl/fac_out_stage.sv
// Result register with a skid stage between the core and the output stream.
`timescale 1ns / 1ps

module fac_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fac_pkg::fac_result_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fac_pkg::fac_result_t out_word
);
    import fac_pkg::*;

    fac_result_t main_reg;
    fac_result_t skid_reg;
    logic        main_valid_reg;
    logic        skid_valid_reg;
    logic        in_fire;
    logic        main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = out_ready || !main_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_fire)
                main_reg <= in_word;
        end
        else if (in_fire)
        begin
            skid_reg <= in_word;
        end
    end

`ifndef SYNTHESIS
    // The skid stage is only ever filled behind a full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without a result word");

    // A parked skid word is moved out as soon as the output drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && main_valid_reg)
        else $error("skid word not advanced");

    // A stalled skid word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid word lost while stalled");
`endif

endmodule

// File: hdl/fall_alert_controller.sv
// Top level of the fall-alert controller.
`timescale 1ns / 1ps
//
// Channel   Direction  Contents
// s_axis    in         one step or tick word: tuser = cmd, tdata = flags and peak
// m_axis    out        one result word per input word
// cfg       in         plain register writes, index 0 blink_period, 1 show_timeout
//
// The mode machine and both counters update on each accepted word; its result
// is registered in the result register, or in the skid stage on output stall.
// A new word is accepted every cycle while the skid stage is empty; a two-entry
// result register and skid stage hold one stalled word before s_tready drops.
// Reset is asynchronous and active low; it puts the block in start mode with
// counters at zero and the registers at 250 and 10000.

module fall_alert_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [fac_pkg::IN_DATA_W-1:0]  s_tdata,  // fall_seen, impact_seen, key_pressed,
                                                      // peak_accel[15:0], pad
    input  logic        s_tuser,  // cmd
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [fac_pkg::OUT_DATA_W-1:0] m_tdata,  // mode_now[1:0], led_on,
                                                      // sensor_setup[1:0],
                                                      // low_power_request, clear_display,
                                                      // display_valid, display_value[15:0],
                                                      // reset_peak, pad
    // Configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import fac_pkg::*;

    fac_item_t   item;
    fac_result_t core_result;
    fac_result_t out_word;
    logic        item_fire;

    // Unpack the input word
    always_comb
    begin
        item.cmd         = s_tuser;
        item.fall_seen   = s_tdata[0];
        item.impact_seen = s_tdata[1];
        item.key_pressed = s_tdata[2];
        item.peak_accel  = s_tdata[18:3];
    end

    assign item_fire = s_tvalid && s_tready;

    fac_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_fire (item_fire),
        .item      (item),
        .result    (core_result)
    );

    fac_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pack the result word
    assign m_tdata = {7'd0,
                      out_word.reset_peak,
                      out_word.display_value,
                      out_word.display_valid,
                      out_word.clear_display,
                      out_word.low_power_request,
                      out_word.sensor_setup,
                      out_word.led_on,
                      out_word.mode_now};

endmodule
